[hw/rtl/bqe_pkg.sv]
// ----------------------------------------------------------------------------
// bqe_pkg
// Shared types, constants and helpers of the bit-quad Euler number block.
// ----------------------------------------------------------------------------
package bqe_pkg;

   localparam int DEFAULT_MAX_WIDTH = 4096;

   localparam int PIXEL_W  = 8;
   localparam int EULER_W  = 24;
   localparam int CFG_W    = 13;
   localparam int CSR_IDX_W = 2;
   localparam int ROW_W    = 12;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int COUNT_W  = 25;
   localparam int NUM_W    = COUNT_W + 3;
   localparam int QUOT_W   = NUM_W - 2;
   localparam int INC_W    = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic signed [QUOT_W-1:0] EULER_LIMIT = QUOT_W'(4194304);

   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EIGHT_CONNECTED = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_NONZERO      = 2'd3;

   localparam logic [CFG_W-1:0] RESET_IMAGE_WIDTH  = 13'd640;
   localparam logic [CFG_W-1:0] RESET_IMAGE_HEIGHT = 13'd480;
   localparam logic RESET_EIGHT_CONNECTED = 1'b0;
   localparam logic RESET_FG_NONZERO      = 1'b1;

   typedef struct packed {
      logic qd;
      logic q3;
      logic q1;
   } quad_class_type;

   // a b / c d : top-left, top-right, bottom-left, bottom-right
   function automatic quad_class_type quad_class(input logic a, input logic b,
                                                  input logic c, input logic d);
      quad_class_type r;
      logic [2:0] n;
      n    = 3'(a) + 3'(b) + 3'(c) + 3'(d);
      r.q1 = (n == 3'd1);
      r.q3 = (n == 3'd3);
      r.qd = (n == 3'd2) && ((a && d) || (b && c));
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] cnt,
                                                   input logic [INC_W-1:0] inc);
      logic [COUNT_W:0] sum;
      sum = {1'b0, cnt} + (COUNT_W+1)'(inc);
      if (sum > {1'b0, COUNT_MAX}) begin
         return COUNT_MAX;
      end
      return sum[COUNT_W-1:0];
   endfunction

endpackage

[hw/rtl/bqe_ram.sv]
// ----------------------------------------------------------------------------
// bqe_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bqe_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bit_quad_euler_number.sv]
// ----------------------------------------------------------------------------
// bit_quad_euler_number
// Euler number of a streamed binary image by 2x2 bit-quad counting.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while req_tready is high and, on
// the last pixel of each image, returns one signed Euler number (objects
// minus holes). The previous row lives in a one-bit line buffer of MAX_WIDTH
// entries; each pixel reads its column when accepted and writes it back from
// the stage behind, with a bypass when the same column is touched by
// consecutive pixels. After reset the line buffer is swept to background,
// during which req_tready stays low. Results wait in an eight-entry queue;
// req_tready drops only while that queue plus results in flight would fill it.
// ----------------------------------------------------------------------------
module bit_quad_euler_number
   import bqe_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   // req_tdata: [7:0] pixel_value
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [PIXEL_W-1:0]        req_tdata,
   // rsp_tdata: [23:0] euler_number
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic signed [EULER_W-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_addr,
   input  logic [CFG_W-1:0]          csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam logic [CW-1:0] COL_LAST = CW'(MAX_WIDTH - 1);

   logic [CFG_W-1:0] cfg_width_ff, cfg_height_ff;
   logic             cfg_eight_ff, cfg_fg_ff;

   logic          clr_active_ff, clr_active_in;
   logic [CW-1:0] clr_addr_ff, clr_addr_in;

   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic                    s1_valid_ff;
   logic                    s1_p_ff, s1_first_row_ff, s1_first_col_ff;
   logic                    s1_last_col_ff, s1_last_row_ff, s1_fwd_ff, s1_fwd_bit_ff;
   logic [CW-1:0]           s1_col_ff;
   logic                    left_ff, left_in, ul_ff, ul_in;
   logic [COUNT_W-1:0]      q1_ff, q1_in, q3_ff, q3_in, qd_ff, qd_in;

   logic                    s2_valid_ff, s2_valid_in;
   logic [COUNT_W-1:0]      s2_q1_ff, s2_q3_ff, s2_qd_ff;
   logic                    s3_valid_ff;
   logic signed [NUM_W-1:0] s3_num_ff, s3_num_in;

   logic [EULER_W-1:0]      fifo_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0]    cnt_ff, cnt_in;

   logic                    accept, pop, p_bit;
   logic [CW-1:0]           wlast;
   logic [ROW_W-1:0]        hlast;
   logic                    last_col, last_row;
   logic                    ram_we, ram_wd, ram_rd;
   logic [CW-1:0]           ram_wa;
   logic                    u, ul, l;
   quad_class_type          c0, c1, c2, c3;
   logic [INC_W-1:0]        inc1, inc3, incd;
   logic [RSP_CNT_W-1:0]    inflight;
   logic signed [QUOT_W-1:0] quot, quot_adj;
   logic [EULER_W-1:0]      euler;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= RESET_IMAGE_WIDTH;
         cfg_height_ff <= RESET_IMAGE_HEIGHT;
         cfg_eight_ff  <= RESET_EIGHT_CONNECTED;
         cfg_fg_ff     <= RESET_FG_NONZERO;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH:     cfg_width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT:    cfg_height_ff <= csr_wdata;
            CSR_EIGHT_CONNECTED: cfg_eight_ff  <= csr_wdata[0];
            CSR_FG_NONZERO:      cfg_fg_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective last column and last row
   always_comb begin
      if (cfg_width_ff == '0) begin
         wlast = '0;
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         wlast = COL_LAST;
      end else begin
         wlast = CW'(cfg_width_ff - 13'd1);
      end
      if (cfg_height_ff == '0) begin
         hlast = '0;
      end else if (32'(cfg_height_ff) > 32'(HEIGHT_LIMIT)) begin
         hlast = ROW_W'(HEIGHT_LIMIT - 1);
      end else begin
         hlast = ROW_W'(cfg_height_ff - 13'd1);
      end
   end

   assign inflight   = RSP_CNT_W'(s1_valid_ff && s1_last_col_ff && s1_last_row_ff)
                     + RSP_CNT_W'(s2_valid_ff) + RSP_CNT_W'(s3_valid_ff);
   assign req_tready = !clr_active_ff && ((cnt_ff + inflight) < RSP_CNT_W'(RSP_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign p_bit      = ((req_tdata != '0) == cfg_fg_ff);
   assign last_col   = (col_ff >= wlast);
   assign last_row   = (row_ff >= hlast);

   // line buffer clearing sweep after reset
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == COL_LAST) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   // raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (!last_col) begin
            col_in = col_ff + 1'b1;
         end else begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_p_ff         <= p_bit;
      s1_col_ff       <= col_ff;
      s1_first_row_ff <= (row_ff == '0);
      s1_first_col_ff <= (col_ff == '0);
      s1_last_col_ff  <= last_col;
      s1_last_row_ff  <= last_row;
      s1_fwd_ff       <= s1_valid_ff && (s1_col_ff == col_ff);
      s1_fwd_bit_ff   <= s1_p_ff;
   end

   assign ram_we = clr_active_ff || s1_valid_ff;
   assign ram_wa = clr_active_ff ? clr_addr_ff : s1_col_ff;
   assign ram_wd = clr_active_ff ? 1'b0 : s1_p_ff;

   bqe_ram #(
      .WIDTH(1),
      .DEPTH(MAX_WIDTH)
   ) u_line_buf (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(col_ff),
      .rd_data(ram_rd)
   );

   // quad classification and counting
   always_comb begin
      u  = s1_first_row_ff ? 1'b0 : (s1_fwd_ff ? s1_fwd_bit_ff : ram_rd);
      ul = (s1_first_row_ff || s1_first_col_ff) ? 1'b0 : ul_ff;
      l  = s1_first_col_ff ? 1'b0 : left_ff;
      c0 = quad_class(ul, u, l, s1_p_ff);
      c1 = s1_last_col_ff ? quad_class(u, 1'b0, s1_p_ff, 1'b0) : '0;
      c2 = s1_last_row_ff ? quad_class(l, s1_p_ff, 1'b0, 1'b0) : '0;
      c3 = (s1_last_row_ff && s1_last_col_ff) ?
           quad_class(s1_p_ff, 1'b0, 1'b0, 1'b0) : '0;
      inc1 = INC_W'(c0.q1) + INC_W'(c1.q1) + INC_W'(c2.q1) + INC_W'(c3.q1);
      inc3 = INC_W'(c0.q3) + INC_W'(c1.q3) + INC_W'(c2.q3) + INC_W'(c3.q3);
      incd = INC_W'(c0.qd) + INC_W'(c1.qd) + INC_W'(c2.qd) + INC_W'(c3.qd);

      q1_in       = q1_ff;
      q3_in       = q3_ff;
      qd_in       = qd_ff;
      left_in     = left_ff;
      ul_in       = ul_ff;
      s2_valid_in = 1'b0;
      if (s1_valid_ff) begin
         q1_in   = sat_add(q1_ff, inc1);
         q3_in   = sat_add(q3_ff, inc3);
         qd_in   = sat_add(qd_ff, incd);
         left_in = s1_p_ff;
         ul_in   = u;
         if (s1_last_col_ff && s1_last_row_ff) begin
            s2_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_ff       <= '0;
         q3_ff       <= '0;
         qd_ff       <= '0;
         left_ff     <= 1'b0;
         ul_ff       <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s2_valid_ff;
         if (s2_valid_in) begin
            q1_ff   <= '0;
            q3_ff   <= '0;
            qd_ff   <= '0;
            left_ff <= 1'b0;
            ul_ff   <= 1'b0;
         end else begin
            q1_ff   <= q1_in;
            q3_ff   <= q3_in;
            qd_ff   <= qd_in;
            left_ff <= left_in;
            ul_ff   <= ul_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s2_q1_ff <= q1_in;
      s2_q3_ff <= q3_in;
      s2_qd_ff <= qd_in;
      s3_num_ff <= s3_num_in;
   end

   // numerator, then divide by four toward zero and clamp
   always_comb begin
      s3_num_in = $signed({3'b000, s2_q1_ff}) - $signed({3'b000, s2_q3_ff});
      if (cfg_eight_ff) begin
         s3_num_in = s3_num_in - $signed({2'b00, s2_qd_ff, 1'b0});
      end else begin
         s3_num_in = s3_num_in + $signed({2'b00, s2_qd_ff, 1'b0});
      end
   end

   always_comb begin
      quot     = s3_num_ff[NUM_W-1:2];
      quot_adj = quot;
      if (s3_num_ff[NUM_W-1] && (s3_num_ff[1:0] != 2'b00)) begin
         quot_adj = quot + QUOT_W'(1);
      end
      if (quot_adj > EULER_LIMIT) begin
         euler = EULER_W'(EULER_LIMIT);
      end else if (quot_adj < -EULER_LIMIT) begin
         euler = EULER_W'(-EULER_LIMIT);
      end else begin
         euler = quot_adj[EULER_W-1:0];
      end
   end

   // result queue
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = $signed(fifo_ff[rd_ptr_ff]);

   always_comb begin
      cnt_in = cnt_ff;
      if (s3_valid_ff && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!s3_valid_ff && pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (s3_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= euler;
      end
   end

endmodule

[bench/bit_quad_euler_number_tb.sv]
// ----------------------------------------------------------------------------
// bit_quad_euler_number_tb
// Self-checking bench for the streaming bit-quad Euler number block.
// ----------------------------------------------------------------------------
// Streams binary images pixel by pixel and predicts, per image, the Euler
// number from its own bit-quad tally with a line buffer, border padding,
// size clamping, saturating counters and signed division. A directed part
// covers single pixels, both diagonals with one under each connectivity, inverted
// polarity, a ring with a hole and a width change in the middle of a row.
// Random groups of small images follow under changing register settings and
// idle patterns, then zero sizes and an oversize image that a later size
// write cuts short. One long receiver hold backs the result queue up into
// the input.
// ----------------------------------------------------------------------------
module bit_quad_euler_number_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bqe_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 12;
   localparam int RANDOM_PIXELS  = 560;
   localparam int RANDOM_FRAMES  = 25;
   localparam int CUT_PIXELS     = 30;
   localparam longint EULER_BOUND = 4194304;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   class euler_scoreboard_type;
      logic [CFG_W-1:0]   width_reg;
      logic [CFG_W-1:0]   height_reg;
      bit                 eight_conn;
      bit                 fg_nonzero;
      bit                 row_bits[DEFAULT_MAX_WIDTH];
      bit                 left_bit;
      bit                 up_left_bit;
      int unsigned        col_pos;
      int unsigned        row_pos;
      logic [COUNT_W-1:0] single_cnt;
      logic [COUNT_W-1:0] triple_cnt;
      logic [COUNT_W-1:0] diag_cnt;
      logic [EULER_W-1:0] euler_q[$];
      int                 errors;

      function new();
         width_reg   = RESET_IMAGE_WIDTH;
         height_reg  = RESET_IMAGE_HEIGHT;
         eight_conn  = RESET_EIGHT_CONNECTED;
         fg_nonzero  = RESET_FG_NONZERO;
         foreach (row_bits[i]) row_bits[i] = 1'b0;
         left_bit    = 1'b0;
         up_left_bit = 1'b0;
         col_pos     = 0;
         row_pos     = 0;
         single_cnt  = '0;
         triple_cnt  = '0;
         diag_cnt    = '0;
         errors      = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         case (idx)
            CSR_IMAGE_WIDTH:     width_reg = value;
            CSR_IMAGE_HEIGHT:    height_reg = value;
            CSR_EIGHT_CONNECTED: eight_conn = value[0];
            CSR_FG_NONZERO:      fg_nonzero = value[0];
            default: ;
         endcase
      endfunction

      function void bump(inout logic [COUNT_W-1:0] cnt);
         if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
      endfunction

      // a b / c d : top-left, top-right, bottom-left, bottom-right
      function void count_quad(bit a, bit b, bit c, bit d);
         int n;
         n = int'(a) + int'(b) + int'(c) + int'(d);
         if (n == 1) bump(single_cnt);
         else if (n == 3) bump(triple_cnt);
         else if (n == 2 && ((a && d) || (b && c))) bump(diag_cnt);
      endfunction

      function void note_pixel(logic [PIXEL_W-1:0] value);
         int unsigned w;
         int unsigned h;
         int unsigned col;
         bit p, u, ul, l, last_col, last_row;
         longint numer;
         longint quotient;
         w = (width_reg == 0) ? 1 : ((width_reg > DEFAULT_MAX_WIDTH) ? DEFAULT_MAX_WIDTH
                                                                      : width_reg);
         h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
         col = col_pos % DEFAULT_MAX_WIDTH;
         p  = ((value != 0) == fg_nonzero);
         u  = (row_pos == 0) ? 1'b0 : row_bits[col];
         ul = (col == 0 || row_pos == 0) ? 1'b0 : up_left_bit;
         l  = (col == 0) ? 1'b0 : left_bit;
         last_col = (col >= w - 1);
         last_row = (row_pos >= h - 1);

         count_quad(ul, u, l, p);
         if (last_col) count_quad(u, 1'b0, p, 1'b0);
         if (last_row) begin
            count_quad(l, p, 1'b0, 1'b0);
            if (last_col) count_quad(p, 1'b0, 1'b0, 1'b0);
         end

         row_bits[col] = p;
         up_left_bit   = u;
         left_bit      = p;

         if (!last_col) begin
            col_pos = col + 1;
            return;
         end
         col_pos = 0;
         if (!last_row) begin
            row_pos++;
            return;
         end

         numer = longint'(single_cnt) - longint'(triple_cnt);
         numer = eight_conn ? numer - 2 * longint'(diag_cnt) : numer + 2 * longint'(diag_cnt);
         quotient = numer / 4;
         if (quotient > EULER_BOUND) quotient = EULER_BOUND;
         if (quotient < -EULER_BOUND) quotient = -EULER_BOUND;
         euler_q.push_back(quotient[EULER_W-1:0]);

         row_pos     = 0;
         left_bit    = 1'b0;
         up_left_bit = 1'b0;
         single_cnt  = '0;
         triple_cnt  = '0;
         diag_cnt    = '0;
      endfunction

      function int unsigned pending();
         return euler_q.size();
      endfunction

      function void check_result(logic [EULER_W-1:0] actual);
         logic [EULER_W-1:0] want;
         if (euler_q.size() == 0) begin
            $error("euler_number: expected none, actual %0d", $signed(actual));
            errors++;
            return;
         end
         want = euler_q.pop_front();
         if (want !== actual) begin
            $error("euler_number: expected %0d, actual %0d", $signed(want), $signed(actual));
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [PIXEL_W-1:0]        req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic signed [EULER_W-1:0] rsp_tdata;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_addr = '0;
   logic [CFG_W-1:0]          csr_wdata = '0;

   euler_scoreboard_type board;
   idle_mode_type   idle_mode = IDLE_NONE;
   logic            hold_trigger = 1'b0;
   bit              hold_taken = 1'b0;
   int              hold_left = 0;
   int              stall_cycles = 0;
   int unsigned     pixels_sent = 0;
   int unsigned     frames_sent = 0;

   bit_quad_euler_number DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int sender_idle_pct();
      case (idle_mode)
         IDLE_SENDER: return 58;
         IDLE_BOTH:   return 22;
         default:     return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (idle_mode)
         IDLE_RECEIVER: return 58;
         IDLE_BOTH:     return 22;
         default:       return 0;
      endcase
   endfunction

   function automatic int unsigned dim_eff(int unsigned value);
      return (value == 0) ? 1 : ((value > 4096) ? 4096 : value);
   endfunction

   function automatic logic [PIXEL_W-1:0] rand_pixel(int density);
      return ($urandom_range(99) < density) ? PIXEL_W'($urandom_range(1, 255)) : '0;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      if (hold_trigger && !hold_taken) begin
         hold_left  = HOLD_CYCLES;
         hold_taken = 1'b1;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct());
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("bit_quad_euler_number test failed");
         $finish;
      end
   end

   task automatic send_pixel(input logic [PIXEL_W-1:0] value);
      while ($urandom_range(99) < sender_idle_pct()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_pixel(value);
      pixels_sent++;
   endtask

   task automatic send_frame(input int unsigned count);
      int density;
      case ($urandom_range(3))
         0:       density = 5;
         1:       density = 50;
         2:       density = 95;
         default: density = $urandom_range(100);
      endcase
      repeat (count) send_pixel(rand_pixel(density));
      frames_sent++;
   endtask

   task automatic send_list(input logic [PIXEL_W-1:0] values[$]);
      foreach (values[i]) send_pixel(values[i]);
   endtask

   // drop valid, wait out every pending result and the pipeline behind it
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.write_register(idx, value);
   endtask

   task automatic configure(input int unsigned w, input int unsigned h,
                            input bit eight, input bit fg);
      settle();
      write_csr(CSR_IMAGE_WIDTH, CFG_W'(w));
      write_csr(CSR_IMAGE_HEIGHT, CFG_W'(h));
      write_csr(CSR_EIGHT_CONNECTED, CFG_W'(eight));
      write_csr(CSR_FG_NONZERO, CFG_W'(fg));
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [PIXEL_W-1:0] pattern[$];
      int unsigned        w;
      int unsigned        h;
      int unsigned        group;
      int unsigned        random_pixels_start;
      int unsigned        random_frames_start;
      int unsigned        big_w[4];
      int unsigned        big_h[4];

      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // single pixel images with the reset connectivity, first with the reset polarity, then inverted
      write_csr(CSR_IMAGE_WIDTH, CFG_W'(1));
      write_csr(CSR_IMAGE_HEIGHT, CFG_W'(1));
      csr_we <= 1'b0;
      send_pixel(8'hFF);
      send_pixel(8'h00);

      settle();
      write_csr(CSR_FG_NONZERO, CFG_W'(0));
      csr_we <= 1'b0;
      send_pixel(8'h00);

      configure(2, 2, 1'b0, 1'b1);
      pattern = {8'h80, 8'h00, 8'h00, 8'h01};
      send_list(pattern);

      configure(2, 2, 1'b1, 1'b1);
      pattern = {8'h00, 8'h7F, 8'h02, 8'h00};
      send_list(pattern);

      // ring around a hole
      configure(3, 3, 1'b0, 1'b1);
      pattern = {8'h10, 8'h20, 8'h40, 8'h04, 8'h00, 8'h08, 8'h01, 8'h02, 8'hFF};
      send_list(pattern);

      // shrink the width while in the middle of a row
      configure(6, 2, 1'b1, 1'b1);
      pattern = {8'h01, 8'h00, 8'h01, 8'h01};
      send_list(pattern);
      settle();
      write_csr(CSR_IMAGE_WIDTH, CFG_W'(3));
      csr_we <= 1'b0;
      pattern = {8'h00, 8'h01, 8'h00, 8'h01};
      send_list(pattern);

      // back up the result queue into the input
      configure(1, 1, 1'b0, 1'b1);
      idle_mode = IDLE_NONE;
      hold_trigger <= 1'b1;
      repeat (40) send_pixel(rand_pixel(50));

      group = 0;
      random_pixels_start = pixels_sent;
      random_frames_start = frames_sent;
      while (pixels_sent - random_pixels_start < RANDOM_PIXELS
             || frames_sent - random_frames_start < RANDOM_FRAMES) begin
         if ($urandom_range(9) == 0) begin
            w = $urandom_range(9, 64);
            h = $urandom_range(1, 3);
         end else begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 6);
         end
         configure(w, h, 1'($urandom_range(1)), 1'($urandom_range(1)));
         idle_mode = idle_mode_type'(group % 4);
         repeat ($urandom_range(1, 4)) send_frame(w * h);
         group++;
      end

      // zero sizes count as one
      big_w = '{0, 37, 0, 6};
      big_h = '{4, 0, 0, 0};
      foreach (big_w[i]) begin
         configure(big_w[i], big_h[i], 1'($urandom_range(1)), 1'($urandom_range(1)));
         idle_mode = idle_mode_type'(i);
         send_frame(dim_eff(big_w[i]) * dim_eff(big_h[i]));
      end

      // oversize sizes, then end the image early by shrinking both
      configure(8191, 8191, 1'($urandom_range(1)), 1'($urandom_range(1)));
      idle_mode = IDLE_BOTH;
      repeat (CUT_PIXELS) send_pixel(rand_pixel(50));
      settle();
      write_csr(CSR_IMAGE_WIDTH, CFG_W'(10));
      write_csr(CSR_IMAGE_HEIGHT, CFG_W'(1));
      csr_we <= 1'b0;
      send_pixel(rand_pixel(50));

      idle_mode = IDLE_NONE;
      settle();
      if (board.errors == 0) begin
         $display("bit_quad_euler_number test passed");
      end else begin
         $display("bit_quad_euler_number test failed");
      end
      $finish;
   end

endmodule
